// ===== hw/rtl/sops_pkg.sv =====
// Shared types and constants for the shift-or pattern search core.
package sops_pkg;

    localparam int PATTERN_MAX_DEF   = 64;
    localparam int ALPHABET_SIZE_DEF = 128;
    localparam int ASCII_LIMIT       = 128;

    localparam int MASK_W     = 64;
    localparam int SYMBOL_W   = 8;
    localparam int COUNT_W    = 32;
    localparam int LEN_W      = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic       CMD_TABLE_WRITE    = 1'b0;
    localparam logic       CMD_TEXT           = 1'b1;
    localparam logic       REG_PATTERN_LENGTH = 1'b0;
    localparam logic       REG_COUNT_MODE     = 1'b1;
    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 7'd1;

    typedef struct packed {
        logic                cmd;
        logic [SYMBOL_W-1:0] symbol;
        logic [MASK_W-1:0]   mask_value;
        logic                last_in_line;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] line_index;
        logic [COUNT_W-1:0] occurrence_count;
    } t_out_item;

endpackage

// ===== hw/rtl/sops_mask_table.sv =====
// Character mask memory with per-entry valid bits; unwritten entries read as all ones.
module sops_mask_table
    import sops_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic                i_rd_en,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic [WIDTH-1:0]    i_wr_data,
    output logic [WIDTH-1:0]    o_mask
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;
    logic             in_range;
    logic [AW-1:0]    addr;

    assign in_range = {1'b0, i_symbol} < 9'(DEPTH);
    assign addr     = i_symbol[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_mem[addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= in_range && r_valid[addr];
            end
        end
    end

    // Symbols outside the table and never-written entries behave as all ones.
    assign o_mask = r_rd_hit ? r_rd_data : '1;

endmodule

// ===== hw/rtl/sops_match_core.sv =====
// Shift-or state vector update, line tracking and saturating counters.
module sops_match_core
    import sops_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_cmd,
    input  logic                   i_last,
    input  logic [PATTERN_MAX-1:0] i_mask,
    input  logic [LEN_W-1:0]       i_pattern_length,
    input  logic                   i_count_mode,
    output t_out_item              o_res
);

    localparam int              PW     = $clog2(PATTERN_MAX);
    localparam logic [LEN_W-1:0] PMAX_L = LEN_W'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0] r_state_vec;
    logic                   r_line_matched;
    logic [COUNT_W-1:0]     r_line_count;
    logic [COUNT_W-1:0]     r_match_count;

    logic [PATTERN_MAX-1:0] n_state_vec;
    logic [COUNT_W-1:0]     n_match_count;
    logic [PW-1:0]          match_pos;
    logic                   is_text;
    logic                   skip;
    logic                   hit;

    always_comb begin
        if (i_pattern_length == '0) begin
            match_pos = '0;
        end else if (i_pattern_length > PMAX_L) begin
            match_pos = PW'(PATTERN_MAX - 1);
        end else begin
            match_pos = PW'(i_pattern_length - LEN_W'(1));
        end
    end

    assign is_text     = (i_cmd == CMD_TEXT);
    assign skip        = i_count_mode && r_line_matched;
    assign n_state_vec = (r_state_vec << 1) | i_mask;
    assign hit         = is_text && !skip && !n_state_vec[match_pos];
    assign n_match_count = (hit && (r_match_count != '1)) ? r_match_count + COUNT_W'(1)
                                                          : r_match_count;

    assign o_res.hit              = hit;
    assign o_res.line_index       = r_line_count;
    assign o_res.occurrence_count = n_match_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_vec    <= '1;
            r_line_matched <= 1'b0;
            r_line_count   <= '0;
            r_match_count  <= '0;
        end else if (i_adv && is_text) begin
            if (!skip) begin
                r_state_vec <= n_state_vec;
            end
            r_match_count <= n_match_count;
            if (i_last) begin
                r_line_matched <= 1'b0;
                if (r_line_count != '1) begin
                    r_line_count <= r_line_count + COUNT_W'(1);
                end
            end else if (hit && i_count_mode) begin
                r_line_matched <= 1'b1;
            end
        end
    end

    a_hit_only_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.hit |-> is_text)
        else $error("hit raised for a table write item");

    a_skip_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_count_mode && r_line_matched) |-> !o_res.hit)
        else $error("second match reported within one line");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_match_count >= $past(r_match_count))
        else $error("match counter decreased");

    a_line_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_adv && is_text && i_last) |=> $stable(r_line_count))
        else $error("line counter moved without a line end");

endmodule

// ===== hw/rtl/shift_or_pattern_search_core.sv =====
// Top level of the shift-or pattern search core: handshake, config registers, pipeline.
//
// Usage: input items arrive on i_in_valid / o_in_ready / i_in_item. A table write item
// (cmd 0) stores the mask of one character in the mask memory; a text item (cmd 1)
// advances the shift-or state vector and may report a match. Every item, table write
// or text, yields exactly one result item on o_out_valid / i_out_ready / o_out_item.
// The mask memory read register and stage 1 load when an item is accepted, and the
// output register, which drives o_out_valid, loads when stage 1 advances, which a stalled
// receiver holds off. While the receiver keeps i_out_ready high, throughput is one item
// per cycle; the state vector and counters are updated in the same cycle the mask
// word returns, so consecutive text characters need no interlock, and a table write
// lands in memory before the next item's read.
// When the receiver stalls, the output register holds its item and the stall reaches
// o_in_ready as soon as the pipeline stage behind it is full.
// Reset clears the state vector to all ones, the counters and line flag to zero,
// and all mask valid bits, so every entry reads as all ones; no clearing pass is needed.
// The user must write registers pattern_length (address 0) and count_mode (address 4)
// over the APB port only while the core is idle; the block does not enforce it.
module shift_or_pattern_search_core
    import sops_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int TABLE_DEPTH = (ALPHABET_SIZE < ASCII_LIMIT) ? ALPHABET_SIZE : ASCII_LIMIT;

    logic [LEN_W-1:0] r_pattern_length;
    logic             r_count_mode;
    logic             r_s1_vld;
    logic             r_s1_cmd;
    logic             r_s1_last;
    logic             r_out_vld;
    t_out_item        r_out_item;

    logic                   in_acc;
    logic                   s1_adv;
    logic                   cfg_wr;
    logic                   reg_idx;
    logic [PATTERN_MAX-1:0] mask;
    t_out_item              res;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(r_pattern_length);
            REG_COUNT_MODE:     prdata = APB_DATA_W'(r_count_mode);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PATTERN_LENGTH_RST;
            r_count_mode     <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[LEN_W-1:0];
                REG_COUNT_MODE:     r_count_mode     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: stage 1 waits for the mask read, then the output register.
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc || (r_s1_vld && !s1_adv);
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_in_item.cmd;
            r_s1_last <= i_in_item.last_in_line;
        end
        if (s1_adv) begin
            r_out_item <= res;
        end
    end

    sops_mask_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (PATTERN_MAX)
    ) u_mask_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && (i_in_item.cmd == CMD_TABLE_WRITE)),
        .i_rd_en   (in_acc && (i_in_item.cmd == CMD_TEXT)),
        .i_symbol  (i_in_item.symbol),
        .i_wr_data (i_in_item.mask_value[PATTERN_MAX-1:0]),
        .o_mask    (mask)
    );

    sops_match_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (s1_adv),
        .i_cmd            (r_s1_cmd),
        .i_last           (r_s1_last),
        .i_mask           (mask),
        .i_pattern_length (r_pattern_length),
        .i_count_mode     (r_count_mode),
        .o_res            (res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

// ===== dv/search_checker.sv =====
// Checker for the shift-or pattern search core: predicts each result and compares it.
`timescale 1ns / 100ps

module search_checker
    import sops_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending_count
);

    localparam int REPORT_LIMIT = 10;

    // Private copy of the block's state and registers.
    logic [MASK_W-1:0]  mask_mem [ALPHABET_SIZE_DEF];
    logic [MASK_W-1:0]  search_vec;
    logic               line_done;
    logic [COUNT_W-1:0] line_count;
    logic [COUNT_W-1:0] match_count;
    logic [LEN_W-1:0]   pat_len;
    logic               line_mode;

    t_out_item          expected_results[$];
    t_out_item          want;
    int                 fail_total;

    function automatic int unsigned match_bit();
        int unsigned len;
        len = 32'(pat_len);
        if (len < 1) len = 1;
        if (len > PATTERN_MAX_DEF) len = PATTERN_MAX_DEF;
        return len - 1;
    endfunction

    function automatic t_out_item predict_search(input t_in_item item);
        t_out_item         res;
        logic [MASK_W-1:0] char_mask;
        res.hit        = 1'b0;
        res.line_index = line_count;
        if (item.cmd == CMD_TABLE_WRITE) begin
            if (item.symbol < ASCII_LIMIT) mask_mem[item.symbol[6:0]] = item.mask_value;
        end else begin
            // In line mode the rest of a line after its first match leaves the state alone.
            if (!(line_mode && line_done)) begin
                char_mask  = (item.symbol < ASCII_LIMIT) ? mask_mem[item.symbol[6:0]] : '1;
                search_vec = (search_vec << 1) | char_mask;
                if (!search_vec[match_bit()]) begin
                    res.hit = 1'b1;
                    if (match_count != '1) match_count = match_count + 1'b1;
                    if (line_mode) line_done = 1'b1;
                end
            end
            if (item.last_in_line) begin
                if (line_count != '1) line_count = line_count + 1'b1;
                line_done = 1'b0;
            end
        end
        res.occurrence_count = match_count;
        return res;
    endfunction

    // Appends one predicted result at the tail of the queue.
    function automatic void enqueue_expected(input t_out_item res);
        expected_results = {expected_results, res};
    endfunction

    always @(posedge i_clk) begin : watch
        if (!i_rst_n) begin
            for (int k = 0; k < ALPHABET_SIZE_DEF; k++) mask_mem[k] = '1;
            search_vec  = '1;
            line_done   = 1'b0;
            line_count  = '0;
            match_count = '0;
            pat_len     = PATTERN_LENGTH_RST;
            line_mode   = 1'b0;
            expected_results.delete();
            fail_total  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH)
                    pat_len = i_pwdata[LEN_W-1:0];
                else if (i_paddr[APB_ADDR_W-1:2] == REG_COUNT_MODE)
                    line_mode = i_pwdata[0];
            end
            // Check departing results before queuing the prediction for a newly accepted item.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected result hit=%0d line=%0d count=%0d",
                                 $realtime, i_out_item.hit, i_out_item.line_index,
                                 i_out_item.occurrence_count);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.hit !== want.hit
                            || i_out_item.line_index !== want.line_index
                            || i_out_item.occurrence_count !== want.occurrence_count) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected hit=%0d line=%0d ",
                                      "count=%0d, got hit=%0d line=%0d count=%0d"},
                                     $realtime, want.hit, want.line_index,
                                     want.occurrence_count, i_out_item.hit,
                                     i_out_item.line_index, i_out_item.occurrence_count);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                enqueue_expected(predict_search(i_in_item));
        end
        o_fail_count    = fail_total;
        o_pending_count = expected_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the shift-or pattern search core.
`timescale 1ns / 100ps

module testbench;
    import sops_pkg::*;

    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 140;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending_count;

    // Idling style, shared by the sender and the receiver.
    bit                    steady_stream;
    bit                    squeeze_req;

    // Pattern of the current phase.
    logic [SYMBOL_W-1:0]   pattern [PATTERN_MAX_DEF];
    logic [SYMBOL_W-1:0]   letters [4];
    int                    n_letters;
    int                    eff_len;
    int                    phase_sent;

    shift_or_pattern_search_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    search_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (out_item),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_stream || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    function automatic t_in_item text_item(input logic [SYMBOL_W-1:0] sym, input logic last);
        t_in_item item;
        item.cmd          = CMD_TEXT;
        item.symbol       = sym;
        item.mask_value   = {$urandom, $urandom};
        item.last_in_line = last;
        return item;
    endfunction

    function automatic t_in_item mask_write_item(input logic [SYMBOL_W-1:0] sym,
                                                 input logic [MASK_W-1:0] mask);
        t_in_item item;
        item.cmd          = CMD_TABLE_WRITE;
        item.symbol       = sym;
        item.mask_value   = mask;
        item.last_in_line = 1'($urandom_range(0, 1));
        return item;
    endfunction

    // Bit j is clear where the pattern holds this symbol at position j.
    function automatic logic [MASK_W-1:0] mask_for(input logic [SYMBOL_W-1:0] sym);
        logic [MASK_W-1:0] mask;
        mask = '1;
        for (int j = 0; j < eff_len; j++)
            if (pattern[j] == sym) mask[j] = 1'b0;
        return mask;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        phase_sent++;
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int len, input logic mode);
        drain();
        write_reg(reg_addr(REG_PATTERN_LENGTH), APB_DATA_W'(len));
        write_reg(reg_addr(REG_COUNT_MODE), APB_DATA_W'(mode));
        eff_len = (len < 1) ? 1 : (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
    endtask

    initial begin : receiver
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                // Long hold-off: the pipeline fills and the input must stall.
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
                squeeze_req = 1'b0;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (steady_stream || $urandom_range(0, 99) < 70) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int          phase_len  [PHASES];
        logic        phase_mode [PHASES];
        int          r;
        int          cut;
        bit          dup;
        logic        last;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady_stream = 1'b0;
        squeeze_req   = 1'b0;
        phase_sent    = 0;
        eff_len       = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: pattern "abc" in occurrence mode.
        configure(3, 1'b0);
        pattern[0] = "a";
        pattern[1] = "b";
        pattern[2] = "c";
        send_item(mask_write_item("a", mask_for("a")));
        send_item(mask_write_item("b", mask_for("b")));
        send_item(mask_write_item("c", mask_for("c")));
        for (int k = 0; k < 6; k++) send_item(text_item(pattern[k % 3], 1'b0));
        // Codes above the table are ignored on write and read as all ones.
        send_item(mask_write_item(8'd255, '0));
        send_item(mask_write_item(8'd128, '0));
        send_item(text_item(8'd255, 1'b0));
        send_item(text_item(8'd128, 1'b0));
        send_item(mask_write_item(8'd0, '0));
        send_item(mask_write_item(8'd127, '0));
        send_item(text_item(8'd0, 1'b0));
        send_item(text_item(8'd127, 1'b0));
        send_item(text_item(8'd0, 1'b1));

        // Line mode with a one-character pattern: later hits in a line are skipped.
        configure(1, 1'b1);
        send_item(mask_write_item("a", ~64'd1));
        send_item(text_item("a", 1'b0));
        send_item(text_item("a", 1'b0));
        send_item(text_item("a", 1'b1));
        send_item(text_item("a", 1'b0));
        // The line flag survives a trip through occurrence mode.
        configure(1, 1'b0);
        send_item(text_item("a", 1'b0));
        configure(1, 1'b1);
        send_item(text_item("a", 1'b0));
        send_item(text_item("a", 1'b1));

        phase_len  = '{1, 64, 0, 127, 3, 0, 0, 64, 5, 0};
        phase_mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        phase_len[5]  = $urandom_range(2, 63);
        phase_len[6]  = $urandom_range(2, 63);
        phase_len[9]  = $urandom_range(2, 63);
        phase_mode[8] = 1'($urandom_range(0, 1));

        for (int p = 0; p < PHASES; p++) begin
            configure(phase_len[p], phase_mode[p]);
            steady_stream = (p == 2 || p == 6 || p == 4);
            n_letters = $urandom_range(2, 4);
            for (int k = 0; k < n_letters; k++) begin
                do begin
                    letters[k] = SYMBOL_W'($urandom_range(0, ASCII_LIMIT - 1));
                    dup = 1'b0;
                    for (int j = 0; j < k; j++) if (letters[j] == letters[k]) dup = 1'b1;
                end while (dup);
            end
            for (int j = 0; j < eff_len; j++)
                pattern[j] = letters[$urandom_range(0, n_letters - 1)];
            phase_sent = 0;
            for (int k = 0; k < n_letters; k++)
                send_item(mask_write_item(letters[k], mask_for(letters[k])));
            if (p == 4) squeeze_req = 1'b1;

            while (phase_sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    for (int j = 0; j < eff_len; j++) begin
                        last = (j == eff_len - 1) && ($urandom_range(0, 3) == 0);
                        send_item(text_item(pattern[j], last));
                    end
                end else if (r < 42) begin
                    // Broken occurrence: a prefix followed by an arbitrary letter.
                    cut = $urandom_range(0, eff_len - 1);
                    for (int j = 0; j < cut; j++) send_item(text_item(pattern[j], 1'b0));
                    send_item(text_item(letters[$urandom_range(0, n_letters - 1)], 1'b0));
                end else if (r < 82) begin
                    send_item(text_item(letters[$urandom_range(0, n_letters - 1)],
                                        $urandom_range(0, 15) == 0));
                end else if (r < 91) begin
                    send_item(text_item(SYMBOL_W'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
                end else if (r < 97) begin
                    send_item(mask_write_item(SYMBOL_W'($urandom_range(0, 255)),
                                              {$urandom, $urandom}));
                end else begin
                    cut = $urandom_range(0, n_letters - 1);
                    send_item(mask_write_item(letters[cut], mask_for(letters[cut])));
                end
            end
        end

        steady_stream = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
